// ===== src/assert_macros.svh =====
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, gated off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== src/pfi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfi_pkg;

    // Table geometry
    localparam int DEPTH      = 1024;
    localparam int COORD_BITS = 20;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Result field widths are fixed by the stream format
    localparam int FS_W       = 11;
    localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((FS_W + 7) / 8) * 8;

    // Operation codes carried in the input tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [ADDR_W-1:0]     t_addr;

    typedef struct packed {
        t_coord y;
        t_coord x;
    } t_entry;

    // One read port and one write port on the point memory
    typedef struct packed {
        logic   rd_en;
        t_addr  rd_addr;
        logic   wr_en;
        t_addr  wr_addr;
        t_entry wr_data;
    } t_mem_req;

    // Finished result handed from the controller to the output register
    typedef struct packed {
        logic            done;
        logic [FS_W-1:0] size;
        logic            flag;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BS_X,
        S_BS_XW,
        S_CHK_W,
        S_BS_Y,
        S_BS_YW,
        S_CP_RD,
        S_CP_WR,
        S_WR_NEW,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== src/pareto_front_insert.sv =====
// Channel   Dir  Request fields (tdata / tuser)
// s_axis    in   tdata: x_coord, y_coord    tuser: operation (1 = clear)
// m_axis    out  tdata: front_size          tuser: full_drop
//
// A clear goes straight to the result. An insert runs a binary search on x and one on y
// over the point memory (about log2(size) steps each, a read and a compare per step),
// with a check read between them if x finds an entry; a dominated point stops there.
// Unless dropped as full, it moves every shifted entry (read, write) and writes a new x.
// Synchronous active-low reset empties the front at once; no clearing pass.
// One item is in work at a time; the result register lets a new request in
// while the previous result waits on m_axis_tready.
`timescale 1ns / 1ps
`default_nettype none

module pareto_front_insert
    import pfi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // x_coord, y_coord
    input  wire logic                  s_axis_tuser,   // operation
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // front_size
    output logic                       m_axis_tuser    // full_drop
);

    t_mem_req        w_mem_req;
    t_entry          w_rd_data;
    t_res            w_res;
    logic            w_res_ready;

    logic            r_out_valid;
    logic [FS_W-1:0] r_out_size;
    logic            r_out_flag;

    assign w_res_ready = !r_out_valid || m_axis_tready;

    pfi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_x         (s_axis_tdata[COORD_BITS-1:0]),
        .i_y         (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_mem_req   (w_mem_req),
        .i_rd_data   (w_rd_data)
    );

    pfi_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_res.done) begin
            r_out_size <= w_res.size;
            r_out_flag <= w_res.flag;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_size);
    assign m_axis_tuser  = r_out_flag;

endmodule

`default_nettype wire

// ===== src/pfi_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfi_mem
    import pfi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== src/pfi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfi_ctrl
    import pfi_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    output logic        o_in_ready,
    input  wire logic   i_op,
    input  wire t_coord i_x,
    input  wire t_coord i_y,
    input  wire logic   i_res_ready,
    output t_res        o_res,
    output t_mem_req    o_mem_req,
    input  wire t_entry i_rd_data
);

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    t_cnt   r_new_count, n_new_count;
    t_coord r_px, n_px;
    t_coord r_py, n_py;
    t_cnt   r_lo, n_lo;
    t_cnt   r_hi, n_hi;
    t_cnt   r_mid, n_mid;
    t_cnt   r_pos, n_pos;
    t_cnt   r_start, n_start;
    t_cnt   r_src, n_src;
    t_cnt   r_shift, n_shift;
    logic   r_present, n_present;
    logic   r_up, n_up;
    logic   r_ins, n_ins;
    logic   r_flag, n_flag;

    t_cnt   w_mid;
    t_cnt   w_run;
    t_cnt   w_src_dec;
    t_cnt   w_dst;

    assign w_mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign w_run     = r_pos - r_lo;
    assign w_src_dec = r_src - 1'b1;
    assign w_dst     = r_src - r_shift;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_new_count <= n_new_count;
        r_px        <= n_px;
        r_py        <= n_py;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_pos       <= n_pos;
        r_start     <= n_start;
        r_src       <= n_src;
        r_shift     <= n_shift;
        r_present   <= n_present;
        r_up        <= n_up;
        r_ins       <= n_ins;
        r_flag      <= n_flag;
    end

    // Next state and working values
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_new_count = r_new_count;
        n_px        = r_px;
        n_py        = r_py;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_pos       = r_pos;
        n_start     = r_start;
        n_src       = r_src;
        n_shift     = r_shift;
        n_present   = r_present;
        n_up        = r_up;
        n_ins       = r_ins;
        n_flag      = r_flag;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_flag = 1'b0;
                    n_px   = i_x;
                    n_py   = i_y;
                    if (i_op == OP_CLEAR) begin
                        n_new_count = '0;
                        n_state     = S_DONE;
                    end else begin
                        n_lo    = '0;
                        n_hi    = r_count;
                        n_state = S_BS_X;
                    end
                end
            end
            // lower bound on x: first entry with x >= px
            S_BS_X: begin
                if (r_lo < r_hi) begin
                    n_mid   = w_mid;
                    n_state = S_BS_XW;
                end else begin
                    n_pos = r_lo;
                    if (r_lo < r_count) begin
                        n_state = S_CHK_W;
                    end else begin
                        n_present = 1'b0;
                        n_hi      = r_lo;
                        n_lo      = '0;
                        n_state   = S_BS_Y;
                    end
                end
            end
            S_BS_XW: begin
                if (i_rd_data.x < r_px) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_BS_X;
            end
            // entry at pos decides domination and duplicate x
            S_CHK_W: begin
                if (r_py < i_rd_data.y) begin
                    n_new_count = r_count;
                    n_state     = S_DONE;
                end else begin
                    n_present = (i_rd_data.x == r_px);
                    n_lo      = '0;
                    n_hi      = r_pos;
                    n_state   = S_BS_Y;
                end
            end
            // first entry below pos with y <= py; y does not rise, so it is a suffix
            S_BS_Y: begin
                if (r_lo < r_hi) begin
                    n_mid   = w_mid;
                    n_state = S_BS_YW;
                end else begin
                    n_start = r_lo;
                    if (!r_present && (r_count - w_run >= CNT_W'(DEPTH))) begin
                        n_flag      = 1'b1;
                        n_new_count = r_count;
                        n_state     = S_DONE;
                    end else if (r_present) begin
                        n_up        = 1'b0;
                        n_shift     = w_run;
                        n_src       = r_pos;
                        n_ins       = 1'b0;
                        n_new_count = r_count - w_run;
                        n_state     = (w_run == '0) ? S_DONE : S_CP_RD;
                    end else if (w_run == '0) begin
                        n_up        = 1'b1;
                        n_shift     = CNT_W'(1);
                        n_src       = r_count;
                        n_ins       = 1'b1;
                        n_new_count = r_count + 1'b1;
                        n_state     = S_CP_RD;
                    end else begin
                        n_up        = 1'b0;
                        n_shift     = w_run - 1'b1;
                        n_src       = r_pos;
                        n_ins       = 1'b1;
                        n_new_count = r_count - w_run + 1'b1;
                        n_state     = (w_run == CNT_W'(1)) ? S_WR_NEW : S_CP_RD;
                    end
                end
            end
            S_BS_YW: begin
                if (i_rd_data.y <= r_py) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + 1'b1;
                end
                n_state = S_BS_Y;
            end
            // move entries one at a time: read, then write back shifted
            S_CP_RD: begin
                if (r_up ? (r_src > r_pos) : (r_src < r_count)) begin
                    n_state = S_CP_WR;
                end else begin
                    n_state = r_ins ? S_WR_NEW : S_DONE;
                end
            end
            S_CP_WR: begin
                n_src   = r_up ? (r_src - 1'b1) : (r_src + 1'b1);
                n_state = S_CP_RD;
            end
            S_WR_NEW: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_count = r_new_count;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs: handshake, result and memory requests
    always_comb begin
        o_in_ready        = 1'b0;
        o_res.done        = 1'b0;
        o_res.size        = r_new_count[FS_W-1:0];
        o_res.flag        = r_flag;
        o_mem_req.rd_en   = 1'b0;
        o_mem_req.rd_addr = r_src[ADDR_W-1:0];
        o_mem_req.wr_en   = 1'b0;
        o_mem_req.wr_addr = r_src[ADDR_W-1:0];
        o_mem_req.wr_data = i_rd_data;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_BS_X: begin
                o_mem_req.rd_en   = 1'b1;
                o_mem_req.rd_addr = (r_lo < r_hi) ? w_mid[ADDR_W-1:0] : r_lo[ADDR_W-1:0];
            end
            S_BS_Y: begin
                o_mem_req.rd_en   = (r_lo < r_hi);
                o_mem_req.rd_addr = w_mid[ADDR_W-1:0];
            end
            S_CP_RD: begin
                o_mem_req.rd_en = 1'b1;
                if (r_up) begin
                    o_mem_req.rd_addr = w_src_dec[ADDR_W-1:0];
                end
            end
            S_CP_WR: begin
                o_mem_req.wr_en = 1'b1;
                if (!r_up) begin
                    o_mem_req.wr_addr = w_dst[ADDR_W-1:0];
                end
            end
            S_WR_NEW: begin
                o_mem_req.wr_en   = 1'b1;
                o_mem_req.wr_addr = r_start[ADDR_W-1:0];
                o_mem_req.wr_data = '{y: r_py, x: r_px};
            end
            S_DONE: begin
                o_res.done = i_res_ready;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/pfi_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pfi_checker
    import pfi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                  m_axis_tuser
);

    logic [FS_W-1:0] w_size;
    assign w_size = m_axis_tdata[FS_W-1:0];

    // A stalled result stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // One item in work at a time: ready drops after a request
    `ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A full drop only happens on a full table
    `ASSERT_IMPLY(a_full_size, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, w_size == FS_W'(DEPTH))

    // The front never exceeds the table
    `ASSERT_IMPLY(a_size_bound, i_clk, i_rst_n, m_axis_tvalid, 32'(w_size) <= 32'(DEPTH))

endmodule

bind pareto_front_insert pfi_checker u_pfi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pfi_pkg::*;

    localparam t_coord MAX_COORD  = '1;
    // Spacing of the staircase used to fill the table
    localparam int     STRIDE     = (1 << COORD_BITS) / DEPTH;
    localparam int     RAND_ITEMS = 550;
    // Worst insert: two searches plus a shift of the whole table
    localparam int     DRAIN_WAIT = 4 * ADDR_W + 2 * DEPTH + 64;
    localparam int     CYCLE_CAP  = 20_000_000;

    typedef enum int {
        MIX_TINY,   // small box, many equal x and y
        MIX_DIAG,   // points near the anti-diagonal, long fronts
        MIX_WIDE,   // full-range random
        MIX_CORNER  // zero, max, single-bit or random coordinates
    } mix_e;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_STARVE
    } rx_mode_e;

    typedef struct {
        logic [FS_W-1:0] front_size;
        logic            full_drop;
    } front_result_t;

    // Tracks the skyline table and the results it owes
    class skyline_tracker;
        t_coord        pts_x [DEPTH];
        t_coord        pts_y [DEPTH];
        int            count;
        front_result_t sizes_due [$];
        int            errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        // Apply one accepted request to the table and queue its result
        function void add_request(logic op, t_coord px, t_coord py);
            int            pos;
            int            start;
            int            run;
            int            k;
            bit            present;
            bit            dropped;
            front_result_t res;
            dropped = 1'b0;
            if (op == OP_CLEAR) begin
                count = 0;
            end else begin
                pos = 0;
                while (pos < count && pts_x[pos] < px)
                    pos++;
                if (!(pos < count && py < pts_y[pos])) begin
                    present = (pos < count) && (pts_x[pos] == px);
                    start = pos;
                    while (start > 0 && pts_y[start-1] <= py)
                        start--;
                    run = pos - start;
                    if (!present && count - run >= DEPTH) begin
                        dropped = 1'b1;
                    end else begin
                        // close the gap left by the dominated run
                        if (run > 0) begin
                            for (k = pos; k < count; k++) begin
                                pts_x[k-run] = pts_x[k];
                                pts_y[k-run] = pts_y[k];
                            end
                            count -= run;
                            pos = start;
                        end
                        // open a slot for the new point
                        if (!present) begin
                            for (k = count; k > pos; k--) begin
                                pts_x[k] = pts_x[k-1];
                                pts_y[k] = pts_y[k-1];
                            end
                            pts_x[pos] = px;
                            pts_y[pos] = py;
                            count++;
                        end
                    end
                end
            end
            res.front_size = FS_W'(count);
            res.full_drop  = dropped;
            sizes_due.push_back(res);
        endfunction

        function void check_result(logic [FS_W-1:0] fs, logic fd);
            front_result_t exp_res;
            if (sizes_due.size() == 0) begin
                $error("unexpected result: front_size=%0d full_drop=%0d", fs, fd);
                errors++;
                return;
            end
            exp_res = sizes_due.pop_front();
            if (fs !== exp_res.front_size) begin
                $error("front_size: expected %0d, actual %0d", exp_res.front_size, fs);
                errors++;
            end
            if (fd !== exp_res.full_drop) begin
                $error("full_drop: expected %0d, actual %0d", exp_res.full_drop, fd);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // x_coord, y_coord
    logic                  s_axis_tuser  = OP_INSERT;  // operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;  // front_size
    logic                  m_axis_tuser;  // full_drop

    skyline_tracker sb = new();

    int       burst_left  = 0;
    int       cycle_count = 0;
    rx_mode_e rx_mode     = RX_OPEN;
    int       rx_left     = 0;
    int       rx_phase    = 0;

    pareto_front_insert DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: check, then set ready from the stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[FS_W-1:0], m_axis_tuser);
        if (rx_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 400);
        end else begin
            rx_left--;
        end
        rx_phase++;
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_axis_tready <= (rx_phase % 7) < 3;
            default:     m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Drive one request and hold it until accepted; idle between bursts
    task automatic send_request(input logic op, input t_coord x, input t_coord y);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({y, x});
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.add_request(op, x, y);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                              : $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // First index at or after from whose x leaves room for a new x just below it, else from
    function automatic int open_slot(int from);
        for (int k = from; k < sb.count; k++)
            if (int'(sb.pts_x[k]) - int'(sb.pts_x[k-1]) > 1)
                return k;
        return from;
    endfunction

    function automatic t_coord corner_value();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return MAX_COORD;
            2:       return t_coord'(1) << $urandom_range(0, COORD_BITS - 1);
            default: return t_coord'($urandom);
        endcase
    endfunction

    initial begin
        int     k;
        int     d;
        int     sent;
        int     seg;
        mix_e   mix;
        logic   op;
        t_coord px;
        t_coord py;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: corners, duplicates, dominated points, removal runs
        send_request(OP_CLEAR,  MAX_COORD, MAX_COORD);
        send_request(OP_INSERT, '0, '0);
        send_request(OP_INSERT, MAX_COORD, MAX_COORD);
        send_request(OP_INSERT, '0, MAX_COORD);
        send_request(OP_INSERT, MAX_COORD, '0);
        send_request(OP_INSERT, MAX_COORD, MAX_COORD);
        send_request(OP_INSERT, '0, MAX_COORD);
        send_request(OP_CLEAR,  '0, '0);
        send_request(OP_INSERT, 20'd100, 20'd500);
        send_request(OP_INSERT, 20'd200, 20'd400);
        send_request(OP_INSERT, 20'd300, 20'd300);
        send_request(OP_INSERT, 20'd400, 20'd200);
        send_request(OP_INSERT, 20'd500, 20'd100);
        send_request(OP_INSERT, 20'd250, 20'd350);
        send_request(OP_INSERT, 20'd350, 20'd450);
        send_request(OP_INSERT, 20'd500, 20'd250);   // same x, still clears a run
        send_request(OP_INSERT, 20'd450, 20'd90);    // dominated
        send_request(OP_INSERT, 20'd600, '0);
        send_request(OP_INSERT, '0, '0);
        send_request(OP_INSERT, 20'd50, MAX_COORD);
        send_request(OP_INSERT, 20'h55555, 20'hAAAAA);
        send_request(OP_INSERT, 20'hAAAAA, 20'h55555);
        send_request(OP_INSERT, MAX_COORD, MAX_COORD);

        // Fill the table with a strict staircase
        send_request(OP_CLEAR, '0, '0);
        for (k = 0; k < DEPTH; k++) begin
            px = t_coord'(k * STRIDE + $urandom_range(0, STRIDE - 2));
            py = t_coord'((DEPTH - 1 - k) * STRIDE + $urandom_range(1, STRIDE - 1));
            send_request(OP_INSERT, px, py);
        end

        // Full table: new x in the middle and past the end are dropped
        k = open_slot($urandom_range(1, DEPTH - 1));
        send_request(OP_INSERT, t_coord'(sb.pts_x[k-1] + 1), sb.pts_y[k]);
        send_request(OP_INSERT, t_coord'(sb.pts_x[DEPTH-1] + 1), '0);
        // existing x is never full
        k = $urandom_range(0, DEPTH - 1);
        send_request(OP_INSERT, sb.pts_x[k], sb.pts_y[k]);
        // new x that removes one point replaces it
        k = $urandom_range(1, DEPTH - 2);
        send_request(OP_INSERT, t_coord'(sb.pts_x[k] + 1), sb.pts_y[k]);
        // remove two near the head, shifting nearly the whole table
        send_request(OP_INSERT, t_coord'(sb.pts_x[2] + 1), sb.pts_y[1]);
        send_request(OP_INSERT, t_coord'(sb.pts_x[sb.count-1] + 1), '0);
        k = open_slot($urandom_range(1, DEPTH - 1));
        send_request(OP_INSERT, t_coord'(sb.pts_x[k-1] + 1), sb.pts_y[k]);
        // last x with top y sweeps the whole front, old entry kept
        send_request(OP_INSERT, sb.pts_x[sb.count-1], MAX_COORD);
        send_request(OP_CLEAR, t_coord'($urandom), t_coord'($urandom));

        // Random segments, each with its own point mix
        sent = 0;
        while (sent < RAND_ITEMS) begin
            mix = mix_e'($urandom_range(0, 3));
            seg = $urandom_range(15, 70);
            for (int i = 0; i < seg; i++) begin
                op = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_INSERT;
                case (mix)
                    MIX_TINY: begin
                        px = t_coord'($urandom_range(0, 15));
                        py = t_coord'($urandom_range(0, 15));
                    end
                    MIX_DIAG: begin
                        px = t_coord'($urandom_range(0, MAX_COORD));
                        d  = int'(MAX_COORD) - int'(px) - int'($urandom_range(0, 4095));
                        py = (d < 0) ? '0 : t_coord'(d);
                    end
                    MIX_WIDE: begin
                        px = t_coord'($urandom);
                        py = t_coord'($urandom);
                    end
                    default: begin
                        px = corner_value();
                        py = corner_value();
                    end
                endcase
                send_request(op, px, py);
                sent++;
            end
        end

        // Drain, then watch for stray results
        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;
        while (sb.sizes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
